FILE: design/drcs_pkg.sv
// ----------------------------------------------------------------------------
// drcs_pkg
// Shared types, constants and helpers for the dirty rectangle coverage block.
// ----------------------------------------------------------------------------
package drcs_pkg;

  // Frame geometry
  localparam int MAX_FRAME_DIM = 8192;
  localparam int DIM_W         = 14;
  localparam int AREA_W        = 2 * DIM_W - 1;   // holds MAX_FRAME_DIM squared
  localparam int COUNT_W       = 16;
  localparam int PERMILLE_W    = 10;

  // Per-mille scale and divider length (quotient never exceeds 1000)
  localparam int PERMILLE      = 1000;
  localparam int DIV_STEPS     = PERMILLE_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  // Shared unit operand and result widths
  localparam int UA_W          = AREA_W + 1;
  localparam int UB_W          = DIM_W;
  localparam int UR_W          = AREA_W + UB_W;

  // Configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // Shared unit operations
  typedef enum logic {
    UOP_MULADD,
    UOP_SUB
  } unit_op_t;

  typedef struct packed {
    unit_op_t            op;
    logic [UA_W-1:0]     a;
    logic [UB_W-1:0]     b;
    logic [AREA_W-1:0]   c;
  } unit_req_t;

  typedef struct packed {
    logic [UR_W-1:0]     res;
    logic                ge;
  } unit_rsp_t;

  // Input item
  typedef struct packed {
    logic signed [15:0]  rect_x;
    logic signed [15:0]  rect_y;
    logic signed [15:0]  rect_width;
    logic signed [15:0]  rect_height;
    logic                rect_empty;
    logic                last_rect;
  } rect_in_t;

  // Result item
  typedef struct packed {
    logic                  stats_valid;
    logic [DIM_W-1:0]      box_x;
    logic [DIM_W-1:0]      box_y;
    logic [DIM_W-1:0]      box_width;
    logic [DIM_W-1:0]      box_height;
    logic [PERMILLE_W-1:0] area_permille;
    logic [COUNT_W-1:0]    rect_count;
  } stats_out_t;

  // Clamp a frame register to the largest supported dimension
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    return (v > DIM_W'(MAX_FRAME_DIM)) ? DIM_W'(MAX_FRAME_DIM) : v;
  endfunction

endpackage

FILE: design/drcs_unit.sv
// ----------------------------------------------------------------------------
// drcs_unit
// Shared arithmetic unit: multiply-add, or trial subtract with compare.
// ----------------------------------------------------------------------------
module drcs_unit (
  input  drcs_pkg::unit_req_t req,
  output drcs_pkg::unit_rsp_t rsp
);
  import drcs_pkg::*;

  logic [UR_W-1:0] prod_sum;
  logic [UR_W-1:0] diff;

  // Multiply-add: a * b + c
  assign prod_sum = UR_W'(req.a[AREA_W-1:0]) * UR_W'(req.b) + UR_W'(req.c);

  // Trial subtract: a - c
  assign diff = UR_W'(req.a) - UR_W'(req.c);

  // Pick result by operation
  always_comb begin
    rsp.ge = (req.a >= UA_W'(req.c));
    unique case (req.op)
      UOP_MULADD: rsp.res = prod_sum;
      UOP_SUB:    rsp.res = diff;
      default:    rsp.res = prod_sum;
    endcase
  end

endmodule

FILE: design/dirty_rect_coverage_stats.sv
// Sequence: a rectangle passes through accept, clip with frame area, area
//   product and accumulate; the last rectangle adds a scale step, 10 divide
//   steps and an output load, which waits while a previous result is still held.
// Input: a new rectangle is accepted only in idle, after the previous one is
//   done; clip, area, accumulate, scale and divide share the single unit.
// Reset: synchronous active low; frame registers read zero, accumulators empty.
// ----------------------------------------------------------------------------
// dirty_rect_coverage_stats
// Accumulates the clipped union box, count and summed area of invalid
// rectangles and reports coverage in per-mille on the last rectangle.
// ----------------------------------------------------------------------------
module dirty_rect_coverage_stats (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic                                cfg_addr,
  input  logic [drcs_pkg::DIM_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  drcs_pkg::rect_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output drcs_pkg::stats_out_t                out_data
);
  import drcs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLIP,
    S_AREA,
    S_ACC,
    S_SCALE,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [DIM_W-1:0]      frame_w_r, frame_h_r;
  rect_in_t              in_r, in_nxt;
  logic [DIM_W-1:0]      l_r, t_r, rr_r, bb_r, dx_r, dy_r;
  logic [DIM_W-1:0]      l_nxt, t_nxt, rr_nxt, bb_nxt, dx_nxt, dy_nxt;
  logic                  ok_r, ok_nxt;
  logic [AREA_W-1:0]     fa_r, fa_nxt, area_r, area_nxt, sum_r, sum_nxt;
  logic [DIM_W-1:0]      min_l_r, min_t_r, max_r_r, max_b_r;
  logic [DIM_W-1:0]      min_l_nxt, min_t_nxt, max_r_nxt, max_b_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [AREA_W-1:0]     rem_r, rem_nxt;
  logic [PERMILLE_W-1:0] low_r, low_nxt, q_r, q_nxt;
  logic [DIV_CNT_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  stats_out_t            out_data_r, out_data_nxt;

  logic [DIM_W-1:0]      fw_eff, fh_eff;
  logic signed [17:0]    x_s, y_s, w_s, h_s, r_s, b_s, l_s, t_s;
  logic signed [17:0]    fw_s, fh_s, rc_s, bc_s;
  logic                  clip_ok;
  logic [AREA_W:0]       acc_sum;
  logic [AREA_W-1:0]     capped;
  logic [UA_W-1:0]       div_trial;
  logic                  out_load;
  stats_out_t            result;
  unit_req_t             ureq;
  unit_rsp_t             ursp;

  drcs_unit u_unit (
    .req (ureq),
    .rsp (ursp)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign fw_eff = eff_dim(frame_w_r);
  assign fh_eff = eff_dim(frame_h_r);

  // Clip the held rectangle to the frame
  always_comb begin
    x_s  = {{2{in_r.rect_x[15]}}, in_r.rect_x};
    y_s  = {{2{in_r.rect_y[15]}}, in_r.rect_y};
    w_s  = {{2{in_r.rect_width[15]}}, in_r.rect_width};
    h_s  = {{2{in_r.rect_height[15]}}, in_r.rect_height};
    fw_s = $signed({4'b0, fw_eff});
    fh_s = $signed({4'b0, fh_eff});
    l_s  = x_s[17] ? '0 : x_s;
    t_s  = y_s[17] ? '0 : y_s;
    r_s  = x_s + w_s;
    b_s  = y_s + h_s;
    rc_s = (r_s > fw_s) ? fw_s : r_s;
    bc_s = (b_s > fh_s) ? fh_s : b_s;
    clip_ok = !in_r.rect_empty && (w_s > 18'sd0) && (h_s > 18'sd0) &&
              (rc_s > l_s) && (bc_s > t_s);
  end

  assign acc_sum   = ursp.res[AREA_W:0];
  assign capped    = (sum_r < fa_r) ? sum_r : fa_r;
  assign div_trial = {rem_r, low_r[PERMILLE_W-1]};
  assign out_load  = !out_valid_r || out_ready;

  // Assemble the result item; zero everything when invalid
  always_comb begin
    result = '0;
    if ((count_r != '0) && (fa_r != '0)) begin
      result.stats_valid   = 1'b1;
      result.box_x         = min_l_r;
      result.box_y         = min_t_r;
      result.box_width     = (max_r_r > min_l_r) ? (max_r_r - min_l_r) : '0;
      result.box_height    = (max_b_r > min_t_r) ? (max_b_r - min_t_r) : '0;
      result.area_permille = q_r;
      result.rect_count    = count_r;
    end
  end

  // Sequencer and shared unit operand selection
  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    l_nxt         = l_r;
    t_nxt         = t_r;
    rr_nxt        = rr_r;
    bb_nxt        = bb_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    ok_nxt        = ok_r;
    fa_nxt        = fa_r;
    area_nxt      = area_r;
    sum_nxt       = sum_r;
    min_l_nxt     = min_l_r;
    min_t_nxt     = min_t_r;
    max_r_nxt     = max_r_r;
    max_b_nxt     = max_b_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    low_nxt       = low_r;
    q_nxt         = q_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ureq          = '{op: UOP_MULADD, a: '0, b: '0, c: '0};

    // Drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = S_CLIP;
        end
      end
      // Hold the clipped edges; frame area on the unit
      S_CLIP: begin
        ureq.a    = UA_W'(fw_eff);
        ureq.b    = fh_eff;
        fa_nxt    = ursp.res[AREA_W-1:0];
        l_nxt     = l_s[DIM_W-1:0];
        t_nxt     = t_s[DIM_W-1:0];
        rr_nxt    = rc_s[DIM_W-1:0];
        bb_nxt    = bc_s[DIM_W-1:0];
        dx_nxt    = DIM_W'(rc_s - l_s);
        dy_nxt    = DIM_W'(bc_s - t_s);
        ok_nxt    = clip_ok;
        state_nxt = S_AREA;
      end
      // Clipped area on the unit
      S_AREA: begin
        ureq.a    = UA_W'(dx_r);
        ureq.b    = dy_r;
        area_nxt  = ursp.res[AREA_W-1:0];
        state_nxt = S_ACC;
      end
      // Add area with cap, widen box, advance count
      S_ACC: begin
        ureq.a = UA_W'(area_r);
        ureq.b = UB_W'(1);
        ureq.c = sum_r;
        if (ok_r) begin
          sum_nxt = (acc_sum > {1'b0, fa_r}) ? fa_r : acc_sum[AREA_W-1:0];
          if (count_r == '0) begin
            min_l_nxt = l_r;
            min_t_nxt = t_r;
            max_r_nxt = rr_r;
            max_b_nxt = bb_r;
          end else begin
            min_l_nxt = (l_r  < min_l_r) ? l_r  : min_l_r;
            min_t_nxt = (t_r  < min_t_r) ? t_r  : min_t_r;
            max_r_nxt = (rr_r > max_r_r) ? rr_r : max_r_r;
            max_b_nxt = (bb_r > max_b_r) ? bb_r : max_b_r;
          end
          if (count_r != '1) begin
            count_nxt = count_r + COUNT_W'(1);
          end
        end
        state_nxt = in_r.last_rect ? S_SCALE : S_IDLE;
      end
      // Numerator: capped * 1000 + frame area / 2
      S_SCALE: begin
        ureq.a      = UA_W'(capped);
        ureq.b      = UB_W'(PERMILLE);
        ureq.c      = fa_r >> 1;
        rem_nxt     = ursp.res[AREA_W+PERMILLE_W-1:PERMILLE_W];
        low_nxt     = ursp.res[PERMILLE_W-1:0];
        q_nxt       = '0;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      // One quotient bit per step
      S_DIV: begin
        ureq.op = UOP_SUB;
        ureq.a  = div_trial;
        ureq.c  = fa_r;
        rem_nxt = ursp.ge ? ursp.res[AREA_W-1:0] : div_trial[AREA_W-1:0];
        low_nxt = {low_r[PERMILLE_W-2:0], 1'b0};
        q_nxt   = {q_r[PERMILLE_W-2:0], ursp.ge};
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        end
      end
      // Load result and restart the accumulators
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result;
          sum_nxt       = '0;
          count_nxt     = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, configuration and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      frame_w_r   <= '0;
      frame_h_r   <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_FRAME_WIDTH:  frame_w_r <= cfg_wdata;
          CFG_FRAME_HEIGHT: frame_h_r <= cfg_wdata;
          default:          frame_w_r <= frame_w_r;
        endcase
      end
    end
    in_r       <= in_nxt;
    l_r        <= l_nxt;
    t_r        <= t_nxt;
    rr_r       <= rr_nxt;
    bb_r       <= bb_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    ok_r       <= ok_nxt;
    fa_r       <= fa_nxt;
    area_r     <= area_nxt;
    min_l_r    <= min_l_nxt;
    min_t_r    <= min_t_nxt;
    max_r_r    <= max_r_nxt;
    max_b_r    <= max_b_nxt;
    rem_r      <= rem_nxt;
    low_r      <= low_nxt;
    q_r        <= q_nxt;
    div_cnt_r  <= div_cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // Summed area stays within the frame area after a contributing accumulate
  a_sum_capped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && ok_r) |=> (sum_r <= fa_r))
    else $error("area sum exceeds frame area");

  // Divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && fa_r != '0) |-> (rem_r < fa_r))
    else $error("divider remainder out of range");

  // Per-mille quotient never exceeds full coverage
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && fa_r != '0) |-> (q_r <= PERMILLE_W'(PERMILLE)))
    else $error("coverage above 1000 per-mille");

  // Accumulators restart once the result is loaded
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_load) |=> (count_r == '0 && sum_r == '0 && out_valid_r))
    else $error("accumulators not cleared after result");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dirty rectangle coverage block. Streams invalid
// rectangles through the valid/ready input, predicts the bounding box, count
// and per-mille coverage of each frame, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;
  import drcs_pkg::*;

  localparam int SETTLE_CYCLES = 40;   // covers a rectangle still in flight
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_ITEMS   = 150;

  // DUT connections
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic                  cfg_addr  = CFG_FRAME_WIDTH;
  logic [DIM_W-1:0]      cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  rect_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  stats_out_t            out_data;

  // Frame registers as last written
  logic [DIM_W-1:0]      frame_w_cfg = '0;
  logic [DIM_W-1:0]      frame_h_cfg = '0;

  // Running frame accumulators
  logic [DIM_W-1:0]      bbox_left    = '0;
  logic [DIM_W-1:0]      bbox_top     = '0;
  logic [DIM_W-1:0]      bbox_right   = '0;
  logic [DIM_W-1:0]      bbox_bottom  = '0;
  logic [AREA_W-1:0]     covered_area = '0;
  logic [COUNT_W-1:0]    hit_count    = '0;

  stats_out_t            expected_stats[$];
  int                    mismatch_cnt   = 0;
  bit                    valid_driven   = 1'b0;
  bit                    sender_gaps_on = 1'b1;
  bit                    sink_stalls_on = 1'b1;
  int                    hold_off_req   = 0;

  dirty_rect_coverage_stats u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Coverage predictor
  // --------------------------------------------------------------------------

  // Registers above the largest supported size saturate
  function automatic int frame_dim(input logic [DIM_W-1:0] v);
    return (v > MAX_FRAME_DIM) ? MAX_FRAME_DIM : int'(v);
  endfunction

  task automatic restart_frame();
    bbox_left    = DIM_W'(frame_dim(frame_w_cfg));
    bbox_top     = DIM_W'(frame_dim(frame_h_cfg));
    bbox_right   = '0;
    bbox_bottom  = '0;
    covered_area = '0;
    hit_count    = '0;
  endtask

  // Clip one rectangle to the current frame and fold it into the totals
  task automatic accumulate_rect(input rect_in_t r);
    int     fw, fh, x, y, w, h, xl, yt, xr, yb;
    longint cap, sum;
    fw = frame_dim(frame_w_cfg);
    fh = frame_dim(frame_h_cfg);
    x  = $signed(r.rect_x);
    y  = $signed(r.rect_y);
    w  = $signed(r.rect_width);
    h  = $signed(r.rect_height);
    if (r.rect_empty || w <= 0 || h <= 0) return;
    xl = (x < 0) ? 0 : x;
    yt = (y < 0) ? 0 : y;
    xr = (x + w > fw) ? fw : x + w;
    yb = (y + h > fh) ? fh : y + h;
    if (xr <= xl || yb <= yt) return;
    // first contributor loads the box, later ones widen it
    if (hit_count == 0) begin
      bbox_left   = DIM_W'(xl);
      bbox_top    = DIM_W'(yt);
      bbox_right  = DIM_W'(xr);
      bbox_bottom = DIM_W'(yb);
    end else begin
      if (xl < bbox_left)   bbox_left   = DIM_W'(xl);
      if (yt < bbox_top)    bbox_top    = DIM_W'(yt);
      if (xr > bbox_right)  bbox_right  = DIM_W'(xr);
      if (yb > bbox_bottom) bbox_bottom = DIM_W'(yb);
    end
    // area sum saturates at the current frame area
    cap = longint'(fw) * longint'(fh);
    sum = longint'(covered_area) + longint'(xr - xl) * longint'(yb - yt);
    if (sum > cap) sum = cap;
    covered_area = AREA_W'(sum);
    if (hit_count != '1) hit_count = hit_count + 1'b1;
  endtask

  // Build the frame result and clear the accumulators
  task automatic close_frame(output stats_out_t s);
    longint fa, capped;
    s  = '0;
    fa = longint'(frame_dim(frame_w_cfg)) * longint'(frame_dim(frame_h_cfg));
    if (hit_count != 0 && fa != 0) begin
      capped          = (longint'(covered_area) < fa) ? longint'(covered_area) : fa;
      s.stats_valid   = 1'b1;
      s.box_x         = bbox_left;
      s.box_y         = bbox_top;
      s.box_width     = (bbox_right > bbox_left) ? bbox_right - bbox_left : '0;
      s.box_height    = (bbox_bottom > bbox_top) ? bbox_bottom - bbox_top : '0;
      s.area_permille = PERMILLE_W'((capped * PERMILLE + fa / 2) / fa);
      s.rect_count    = hit_count;
    end
    restart_frame();
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic compare_field(input string name, input logic [31:0] e,
                               input logic [31:0] a);
    if (e !== a) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("ERROR: %s expected %0d, got %0d at %0t", name, e, a, $realtime);
    end
  endtask

  always @(posedge clk) begin : stats_checker
    stats_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_stats.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("ERROR: result %h arrived with none pending at %0t",
                   out_data, $realtime);
      end else begin
        want = expected_stats.pop_front();
        compare_field("stats_valid",   want.stats_valid,   out_data.stats_valid);
        compare_field("box_x",         want.box_x,         out_data.box_x);
        compare_field("box_y",         want.box_y,         out_data.box_y);
        compare_field("box_width",     want.box_width,     out_data.box_width);
        compare_field("box_height",    want.box_height,    out_data.box_height);
        compare_field("area_permille", want.area_permille, out_data.area_permille);
        compare_field("rect_count",    want.rect_count,    out_data.rect_count);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: random stalls plus requested long hold-offs
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_sink
    int roll;
    int stall_left;
    if (hold_off_req != 0) begin
      stall_left   = hold_off_req;
      hold_off_req = 0;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!sink_stalls_on) begin
      out_ready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left = (roll < 96) ? $urandom_range(0, 3) : $urandom_range(10, 60);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly back-to-back, sometimes short gaps, rarely long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic rect_in_t mk_rect(input int x, input int y, input int w,
                                       input int h, input bit empty, input bit last);
    rect_in_t r;
    r.rect_x      = x[15:0];
    r.rect_y      = y[15:0];
    r.rect_width  = w[15:0];
    r.rect_height = h[15:0];
    r.rect_empty  = empty;
    r.last_rect   = last;
    return r;
  endfunction

  // Offer one item, hold it until accepted, then predict its effect
  task automatic send_rect(input rect_in_t r);
    stats_out_t s;
    int         gap;
    in_data      <= r;
    in_valid     <= 1'b1;
    valid_driven = 1'b1;
    do @(posedge clk); while (!in_ready);
    accumulate_rect(r);
    if (r.last_rect) begin
      close_frame(s);
      expected_stats.push_back(s);
    end
    gap = sender_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid     <= 1'b0;
      valid_driven = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid if the last item left it high
  task automatic quiet_input();
    if (valid_driven) begin
      in_valid     <= 1'b0;
      valid_driven = 1'b0;
    end
  endtask

  // Wait for every pending result, then let in-flight rectangles drain
  task automatic await_idle();
    quiet_input();
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both frame registers while the block is idle
  task automatic set_frame(input int w, input int h);
    await_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_FRAME_WIDTH;
    cfg_wdata <= DIM_W'(w);
    @(posedge clk);
    frame_w_cfg = DIM_W'(w);
    cfg_addr  <= CFG_FRAME_HEIGHT;
    cfg_wdata <= DIM_W'(h);
    @(posedge clk);
    frame_h_cfg = DIM_W'(h);
    cfg_we    <= 1'b0;
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 4))
      0:       return -32768;
      1:       return -1;
      2:       return 0;
      3:       return 1;
      default: return 32767;
    endcase
  endfunction

  // Random rectangle: mostly near the frame, some raw noise and skips
  function automatic rect_in_t rand_rect();
    rect_in_t r;
    int       sw, sh, x, y, w, h, roll;
    sw   = (frame_dim(frame_w_cfg) == 0) ? 64 : frame_dim(frame_w_cfg);
    sh   = (frame_dim(frame_h_cfg) == 0) ? 64 : frame_dim(frame_h_cfg);
    roll = $urandom_range(0, 99);
    x    = int'($urandom_range(0, sw + sw / 4)) - sw / 8;
    y    = int'($urandom_range(0, sh + sh / 4)) - sh / 8;
    if ($urandom_range(0, 1)) begin
      w = $urandom_range(1, sw / 8 + 1);
      h = $urandom_range(1, sh / 8 + 1);
    end else begin
      w = $urandom_range(1, sw);
      h = $urandom_range(1, sh);
    end
    if (roll >= 75 && roll < 90) begin
      x = $urandom();
      y = $urandom();
      w = $urandom();
      h = $urandom();
    end else if (roll >= 90 && roll < 97) begin
      if ($urandom_range(0, 1)) w = -int'($urandom_range(0, 32768));
      else                      h = -int'($urandom_range(0, 32768));
    end else if (roll >= 97) begin
      x = pick_extreme();
      y = pick_extreme();
      w = pick_extreme();
      h = pick_extreme();
    end
    r = mk_rect(x, y, w, h, ($urandom_range(0, 19) == 0), 1'b0);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Zero frame straight out of reset: result must be invalid
  task automatic test_zero_frame();
    send_rect(mk_rect(0, 0, 10, 10, 1'b0, 1'b1));
  endtask

  // Skips, clipping on every edge, field extremes and area saturation
  task automatic test_clipping();
    set_frame(640, 480);
    send_rect(mk_rect(-32768, -32768, 32767, 32767, 1'b0, 1'b0));
    send_rect(mk_rect(32767, 32767, 32767, 32767, 1'b0, 1'b0));
    send_rect(mk_rect(0, 0, 0, 10, 1'b0, 1'b0));
    send_rect(mk_rect(0, 0, 10, -32768, 1'b0, 1'b0));
    send_rect(mk_rect(10, 10, 20, 20, 1'b1, 1'b0));
    send_rect(mk_rect(-5, -5, 10, 10, 1'b0, 1'b1));
    send_rect(mk_rect(600, 400, 100, 100, 1'b0, 1'b0));
    send_rect(mk_rect(10, 20, 30, 40, 1'b0, 1'b0));
    send_rect(mk_rect(0, 0, 640, 480, 1'b0, 1'b1));
    // last item empty with nothing before it
    send_rect(mk_rect(0, 0, 10, 10, 1'b1, 1'b1));
  endtask

  // Per-mille halves round up; smallest share of the largest frame
  task automatic test_rounding();
    set_frame(2000, 1);
    send_rect(mk_rect(0, 0, 1, 1, 1'b0, 1'b1));
    send_rect(mk_rect(0, 0, 3, 1, 1'b0, 1'b1));
    set_frame(MAX_FRAME_DIM, MAX_FRAME_DIM);
    send_rect(mk_rect(8191, 8191, 1, 1, 1'b0, 1'b1));
  endtask

  // Register values beyond the supported size act as the maximum
  task automatic test_oversize_frame();
    set_frame(16383, MAX_FRAME_DIM + 1);
    send_rect(mk_rect(-100, -100, 32767, 32767, 1'b0, 1'b1));
  endtask

  // Frame shrinks mid-frame, then drops to zero before the last item
  task automatic test_frame_change();
    set_frame(100, 100);
    send_rect(mk_rect(90, 90, 20, 20, 1'b0, 1'b0));
    set_frame(50, 50);
    send_rect(mk_rect(40, 40, 20, 20, 1'b0, 1'b0));
    send_rect(mk_rect(0, 0, 5, 5, 1'b0, 1'b1));
    send_rect(mk_rect(0, 0, 5, 5, 1'b0, 1'b0));
    set_frame(0, 50);
    send_rect(mk_rect(0, 0, 5, 5, 1'b0, 1'b1));
  endtask

  // Hold the sink off while the sender keeps offering frame-ending items
  task automatic test_backpressure();
    set_frame(64, 64);
    sender_gaps_on = 1'b0;
    hold_off_req   = 400;
    repeat (30) begin
      send_rect(mk_rect($urandom_range(0, 60), $urandom_range(0, 60),
                        $urandom_range(1, 16), $urandom_range(1, 16), 1'b0, 1'b1));
    end
    sender_gaps_on = 1'b1;
    await_idle();
  endtask

  // Random frames of random length over a range of frame settings
  task automatic test_random_frames();
    rect_in_t r;
    int       phase, sent, len, i;
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0:       set_frame(640, 480);
        1:       set_frame(MAX_FRAME_DIM, MAX_FRAME_DIM);
        2:       set_frame(1, 1);
        3:       set_frame(16383, 16383);
        4:       set_frame(0, $urandom_range(1, 200));
        5:       set_frame(MAX_FRAME_DIM, 1);
        6:       set_frame(1, MAX_FRAME_DIM);
        7:       set_frame($urandom_range(1, 64), $urandom_range(1, 64));
        default: set_frame($urandom_range(1, MAX_FRAME_DIM), $urandom_range(1, 2000));
      endcase
      // some phases run without idling on one side
      sender_gaps_on = (phase % 4 != 1);
      sink_stalls_on = (phase % 4 != 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = $urandom_range(1, 8);
        for (i = 0; i < len; i++) begin
          if (i != 0 && $urandom_range(0, 19) == 0)
            set_frame($urandom_range(0, 300), $urandom_range(0, 300));
          r           = rand_rect();
          r.last_rect = (i == len - 1);
          send_rect(r);
          if (!r.rect_empty) sent++;
        end
      end
    end
    sender_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    restart_frame();
    @(posedge clk);
    test_zero_frame();
    test_clipping();
    test_rounding();
    test_oversize_frame();
    test_frame_change();
    test_backpressure();
    test_random_frames();
    await_idle();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
